FILE: hw/rtl/mpwa_pkg.sv
package mpwa_pkg;

  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned MAX_HEIGHT   = 64;
  localparam int unsigned MAX_WIDTH    = 64;
  localparam int unsigned MAX_KERNEL   = 8;
  localparam int unsigned MAX_STEP     = 8;

  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned KER_W   = 4;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned PAD_W   = 3;
  localparam int unsigned PIX_W   = 32;

  localparam int unsigned MAP_WORDS = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned ADDR_W    = $clog2(MAP_WORDS);
  localparam int unsigned PLANE_W   = 13;
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned SADDR_W   = 20;
  localparam int unsigned CNT_W     = $clog2(MAX_KERNEL);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT      = 4'd7;

  typedef struct packed {
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  w;
    logic [KER_W-1:0]  kh;
    logic [KER_W-1:0]  kw;
    logic [STEP_W-1:0] sr;
    logic [STEP_W-1:0] sc;
    logic [PAD_W-1:0]  pt;
    logic [PAD_W-1:0]  pl;
  } cfg_t;

  typedef struct packed {
    logic                      is_query;
    logic                      store_ok;
    logic signed [SADDR_W-1:0] addr;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x0;
    logic [PIX_W-1:0]          pixel;
  } job_t;

endpackage

FILE: hw/rtl/max_pool_window_argmax_unit.sv
// Max pooling engine with top and left padding over a 64K-word on-chip feature map.
// A store request writes one signed Q16.16 pixel and gives no result; a query
// request returns the window maximum, the flat index of its first occurrence and a
// flag for a non-empty window. The front end takes a new request only once it has
// pushed the last one, and works out the window origin and start address; a two-entry
// queue separates it from the back end, which performs the memory access. A store is
// written as the back end pops it. A query visits the window positions one at a time,
// because the feature map has a single read port and every position, in bounds or not,
// is visited once. A finished result waits in an output register while further
// requests are taken. The feature map has no reset and no clearing pass: read only
// entries that have been written.
module max_pool_window_argmax_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic [mpwa_pkg::CHAN_W-1:0]           chan_i,
  input  logic [mpwa_pkg::POS_W-1:0]            row_pos_i,
  input  logic [mpwa_pkg::POS_W-1:0]            col_pos_i,
  input  logic signed [mpwa_pkg::PIX_W-1:0]     pixel_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mpwa_pkg::PIX_W-1:0]     peak_value_o,
  output logic [mpwa_pkg::ADDR_W-1:0]           peak_index_o,
  output logic                                  any_valid_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mpwa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mpwa_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import mpwa_pkg::*;

  logic [DIM_W-1:0]  img_h_q;
  logic [DIM_W-1:0]  img_w_q;
  logic [KER_W-1:0]  win_h_q;
  logic [KER_W-1:0]  win_w_q;
  logic [STEP_W-1:0] step_r_q;
  logic [STEP_W-1:0] step_c_q;
  logic [PAD_W-1:0]  pad_t_q;
  logic [PAD_W-1:0]  pad_l_q;

  cfg_t cfg;
  job_t front_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q  <= DIM_W'(MAX_HEIGHT);
      img_w_q  <= DIM_W'(MAX_WIDTH);
      win_h_q  <= KER_W'(2);
      win_w_q  <= KER_W'(2);
      step_r_q <= STEP_W'(2);
      step_c_q <= STEP_W'(2);
      pad_t_q  <= '0;
      pad_l_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_WINDOW_HEIGHT: win_h_q  <= cfg_data_i[KER_W-1:0];
        REG_WINDOW_WIDTH:  win_w_q  <= cfg_data_i[KER_W-1:0];
        REG_STEP_ROWS:     step_r_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_COLS:     step_c_q <= cfg_data_i[STEP_W-1:0];
        REG_PAD_TOP:       pad_t_q  <= cfg_data_i[PAD_W-1:0];
        REG_PAD_LEFT:      pad_l_q  <= cfg_data_i[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate out-of-range settings
  always_comb begin
    cfg.h  = (img_h_q == '0) ? DIM_W'(1) :
             (img_h_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_h_q;
    cfg.w  = (img_w_q == '0) ? DIM_W'(1) :
             (img_w_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_w_q;
    cfg.kh = (win_h_q == '0) ? KER_W'(1) :
             (win_h_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : win_h_q;
    cfg.kw = (win_w_q == '0) ? KER_W'(1) :
             (win_w_q > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : win_w_q;
    cfg.sr = (step_r_q == '0) ? STEP_W'(1) :
             (step_r_q > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : step_r_q;
    cfg.sc = (step_c_q == '0) ? STEP_W'(1) :
             (step_c_q > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : step_c_q;
    cfg.pt = pad_t_q;
    cfg.pl = pad_l_q;
  end

  mpwa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .chan_i        (chan_i),
    .row_pos_i     (row_pos_i),
    .col_pos_i     (col_pos_i),
    .pixel_value_i (pixel_value_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (front_job)
  );

  mpwa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  mpwa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .peak_value_o (peak_value_o),
    .peak_index_o (peak_index_o),
    .any_valid_o  (any_valid_o)
  );

endmodule

FILE: hw/rtl/mpwa_front.sv
module mpwa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mpwa_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [mpwa_pkg::CHAN_W-1:0]       chan_i,
  input  logic [mpwa_pkg::POS_W-1:0]        row_pos_i,
  input  logic [mpwa_pkg::POS_W-1:0]        col_pos_i,
  input  logic signed [mpwa_pkg::PIX_W-1:0] pixel_value_i,
  input  logic                              full_i,
  output logic                              push_o,
  output mpwa_pkg::job_t                    job_o
);
  import mpwa_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} state_e;

  state_e state_q;

  logic                      func_q;
  logic [CHAN_W-1:0]         chan_q;
  logic [POS_W-1:0]          row_q;
  logic [POS_W-1:0]          col_q;
  logic [PIX_W-1:0]          pixel_q;
  logic [PLANE_W-1:0]        plane_q;
  logic signed [COORD_W-1:0] y0_q;
  logic signed [COORD_W-1:0] x0_q;
  logic                      ok_q;
  logic [ADDR_W-1:0]         base_q;
  logic signed [SADDR_W-1:0] yw_q;

  logic [PLANE_W-1:0]        plane_d;
  logic [COORD_W-1:0]        rs;
  logic [COORD_W-1:0]        cs;
  logic signed [COORD_W-1:0] y0_d;
  logic signed [COORD_W-1:0] x0_d;
  logic                      ok_d;
  logic [ADDR_W-1:0]         base_d;
  logic signed [SADDR_W-1:0] y0_ext;
  logic signed [SADDR_W-1:0] w_ext;
  logic signed [SADDR_W-1:0] yw_d;
  logic signed [SADDR_W-1:0] base_ext;
  logic signed [SADDR_W-1:0] x0_ext;

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    plane_d = PLANE_W'(cfg_i.h) * PLANE_W'(cfg_i.w);
    rs      = COORD_W'(row_q) * COORD_W'(cfg_i.sr);
    cs      = COORD_W'(col_q) * COORD_W'(cfg_i.sc);
    if (func_q == FUNC_QUERY) begin
      y0_d = signed'(rs - COORD_W'(cfg_i.pt));
      x0_d = signed'(cs - COORD_W'(cfg_i.pl));
    end else begin
      y0_d = signed'(COORD_W'(row_q));
      x0_d = signed'(COORD_W'(col_q));
    end
    ok_d = (DIM_W'(row_q) < cfg_i.h) && (DIM_W'(col_q) < cfg_i.w);
  end

  always_comb begin
    base_d   = ADDR_W'(chan_q) * ADDR_W'(plane_q);
    y0_ext   = SADDR_W'(y0_q);
    w_ext    = signed'(SADDR_W'(cfg_i.w));
    yw_d     = y0_ext * w_ext;
    base_ext = signed'(SADDR_W'(base_q));
    x0_ext   = SADDR_W'(x0_q);
  end

  always_comb begin
    job_o.is_query = (func_q == FUNC_QUERY);
    job_o.store_ok = ok_q;
    job_o.addr     = base_ext + yw_q + x0_ext;
    job_o.y0       = y0_q;
    job_o.x0       = x0_q;
    job_o.pixel    = pixel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) state_q <= F_MUL1;
        end
        F_MUL1: state_q <= F_MUL2;
        F_MUL2: state_q <= F_PUSH;
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      chan_q  <= chan_i;
      row_q   <= row_pos_i;
      col_q   <= col_pos_i;
      pixel_q <= pixel_value_i;
    end
    if (state_q == F_MUL1) begin
      plane_q <= plane_d;
      y0_q    <= y0_d;
      x0_q    <= x0_d;
      ok_q    <= ok_d;
    end
    if (state_q == F_MUL2) begin
      base_q <= base_d;
      yw_q   <= yw_d;
    end
  end

endmodule

FILE: hw/rtl/mpwa_fifo.sv
module mpwa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpwa_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mpwa_pkg::job_t job_o
);
  import mpwa_pkg::*;

  job_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= job_i;
  end

endmodule

FILE: hw/rtl/mpwa_back.sv
module mpwa_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mpwa_pkg::cfg_t                     cfg_i,
  input  logic                               empty_i,
  input  mpwa_pkg::job_t                     job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mpwa_pkg::PIX_W-1:0]  peak_value_o,
  output logic [mpwa_pkg::ADDR_W-1:0]        peak_index_o,
  output logic                               any_valid_o
);
  import mpwa_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_LAST, B_OUT} state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          i_q;
  logic [CNT_W-1:0]          j_q;
  logic signed [COORD_W-1:0] y_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] x0_q;
  logic signed [SADDR_W-1:0] row_addr_q;
  logic signed [SADDR_W-1:0] pos_addr_q;
  logic                      rd_vld_q;
  logic                      found_q;
  logic signed [PIX_W-1:0]   best_q;
  logic [ADDR_W-1:0]         bidx_q;
  logic                      out_valid_q;
  logic signed [PIX_W-1:0]   out_value_q;
  logic [ADDR_W-1:0]         out_index_q;
  logic                      out_any_q;

  logic [PIX_W-1:0]          mem [MAP_WORDS];
  logic signed [PIX_W-1:0]   rdata_q;
  logic [ADDR_W-1:0]         rd_idx_q;

  logic                      inb;
  logic                      rd_en;
  logic                      mem_we;
  logic                      row_end;
  logic                      last_row;
  logic                      better;
  logic                      out_load;
  logic signed [SADDR_W-1:0] next_row_addr;

  always_comb begin
    inb = (y_q >= 0) && (y_q < signed'(COORD_W'(cfg_i.h))) &&
          (x_q >= 0) && (x_q < signed'(COORD_W'(cfg_i.w)));
    rd_en         = (state_q == B_SCAN) && inb;
    mem_we        = (state_q == B_IDLE) && !empty_i && !job_i.is_query && job_i.store_ok;
    pop_o         = (state_q == B_IDLE) && !empty_i;
    row_end       = ({1'b0, j_q} == cfg_i.kw - KER_W'(1));
    last_row      = ({1'b0, i_q} == cfg_i.kh - KER_W'(1));
    better        = rd_vld_q && (!found_q || (rdata_q > best_q));
    out_load      = (state_q == B_OUT) && (!out_valid_q || out_ready_i);
    next_row_addr = row_addr_q + signed'(SADDR_W'(cfg_i.w));
  end

  assign out_valid_o  = out_valid_q;
  assign peak_value_o = out_value_q;
  assign peak_index_o = out_index_q;
  assign any_valid_o  = out_any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      y_q         <= '0;
      x_q         <= '0;
      x0_q        <= '0;
      row_addr_q  <= '0;
      pos_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_index_q <= '0;
      out_any_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (better) begin
        found_q <= 1'b1;
        best_q  <= rdata_q;
        bidx_q  <= rd_idx_q;
      end
      if (out_valid_q && out_ready_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!empty_i && job_i.is_query) begin
            state_q    <= B_SCAN;
            i_q        <= '0;
            j_q        <= '0;
            y_q        <= job_i.y0;
            x_q        <= job_i.x0;
            x0_q       <= job_i.x0;
            row_addr_q <= job_i.addr;
            pos_addr_q <= job_i.addr;
            found_q    <= 1'b0;
            best_q     <= '0;
            bidx_q     <= '0;
          end
        end
        B_SCAN: begin
          if (row_end) begin
            j_q        <= '0;
            x_q        <= x0_q;
            i_q        <= i_q + CNT_W'(1);
            y_q        <= y_q + COORD_W'(1);
            row_addr_q <= next_row_addr;
            pos_addr_q <= next_row_addr;
            if (last_row) state_q <= B_LAST;
          end else begin
            j_q        <= j_q + CNT_W'(1);
            x_q        <= x_q + COORD_W'(1);
            pos_addr_q <= pos_addr_q + SADDR_W'(1);
          end
        end
        B_LAST: state_q <= B_OUT;
        B_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_value_q <= best_q;
            out_index_q <= bidx_q;
            out_any_q   <= found_q;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[job_i.addr[ADDR_W-1:0]] <= job_i.pixel;
    if (rd_en) begin
      rdata_q  <= mem[pos_addr_q[ADDR_W-1:0]];
      rd_idx_q <= pos_addr_q[ADDR_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == B_SCAN))
    else $error("read result without a scan cycle");

  a_store_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == B_IDLE) && !rd_vld_q)
    else $error("store overlaps a window scan");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN) |-> ({1'b0, i_q} < cfg_i.kh) && ({1'b0, j_q} < cfg_i.kw))
    else $error("window counters out of range");

  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) |-> !rd_vld_q)
    else $error("result taken before last compare");
`endif

endmodule
